### rtl/core/gppa_pkg.sv
`default_nettype none
package gppa_pkg;
    localparam int unsigned DefPages = 1024;
    localparam int unsigned AddrW = 48;
    localparam int unsigned SizeW = 26;
    localparam int unsigned CntW = 11;
    localparam int unsigned ShiftW = 5;
    localparam int unsigned AlignW = 7;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 48;
    localparam int unsigned DefFrontAlign = 16;
    localparam int unsigned MinShift = 12;
    localparam int unsigned MaxShift = 16;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_COUNT = 2'd3;

    localparam logic [1:0] ALU_ADD  = 2'd0;
    localparam logic [1:0] ALU_SUB  = 2'd1;
    localparam logic [1:0] ALU_PASS = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PAGE_SHIFT  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_POOL_PAGES  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_FRONT_ALIGN = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [SizeW-1:0] request_size;
        logic [AddrW-1:0] address;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [AddrW-1:0] block_address;
        logic [SizeW-1:0] block_size;
        logic [CntW-1:0]  free_pages;
        logic [CntW-1:0]  used_pages;
    } t_rsp;
endpackage
`default_nettype wire

### rtl/core/gppa_req_if.sv
`default_nettype none
interface gppa_req_if;
    logic valid;
    logic ready;
    gppa_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/gppa_rsp_if.sv
`default_nettype none
interface gppa_rsp_if;
    logic valid;
    logic ready;
    gppa_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/gppa_ram.sv
`default_nettype none
module gppa_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(Depth)-1:0] i_waddr,
    input  wire  [Width-1:0]         i_wdata,
    input  wire  [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/gppa_addr_unit.sv
`default_nettype none
// shared add/compare/subtract unit for address math, one op per cycle
module gppa_addr_unit (
    input  wire                          i_clk,
    input  wire  [1:0]                   i_fn,
    input  wire  [gppa_pkg::AddrW:0]     i_a,
    input  wire  [gppa_pkg::AddrW:0]     i_b,
    output logic [gppa_pkg::AddrW:0]     o_sum,
    output logic                         o_lt
);
    always_ff @(posedge i_clk) begin
        case (i_fn)
            gppa_pkg::ALU_ADD: o_sum <= i_a + i_b;
            gppa_pkg::ALU_SUB: o_sum <= i_a - i_b;
            default:           o_sum <= i_a;
        endcase
        o_lt <= i_a < i_b;
    end
endmodule
`default_nettype wire

### rtl/core/guard_page_pool_allocator.sv
`default_nettype none
// channel   dir  payload
// i_req     in   op, request_size, address
// o_rsp     out  ok, block_address, block_size, free_pages, used_pages
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
// after reset a clearing pass zeroes every table entry before the first beat
// allocate checks one page per round of the SCAN, SCANW and RDW states, over up to two passes, then marks the run
// free walks the run one page per cycle
// alignment is a restoring divide and a shift-add multiply
// one item at a time; the result register holds until the output beat is taken
module guard_page_pool_allocator #(
    parameter int unsigned PAGES = gppa_pkg::DefPages
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [gppa_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  wire  [gppa_pkg::CfgDataW-1:0]    i_cfg_data,
    gppa_req_if.sink                         i_req,
    gppa_rsp_if.source                       o_rsp
);
    localparam int unsigned IW = $clog2(PAGES);
    localparam int unsigned PW = $clog2(PAGES + 1) > gppa_pkg::CntW ?
                                 $clog2(PAGES + 1) : gppa_pkg::CntW;
    localparam int unsigned AW = gppa_pkg::AddrW;
    localparam int unsigned SW = gppa_pkg::SizeW;
    localparam int unsigned CW = gppa_pkg::CntW;
    localparam int unsigned EW = CW + SW;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_NEED  = 5'd2;
    localparam logic [4:0] S_SCAN  = 5'd3;
    localparam logic [4:0] S_SCANW = 5'd4;
    localparam logic [4:0] S_MARK  = 5'd5;
    localparam logic [4:0] S_ST    = 5'd6;
    localparam logic [4:0] S_LAST  = 5'd7;
    localparam logic [4:0] S_BND   = 5'd8;
    localparam logic [4:0] S_DIV0  = 5'd9;
    localparam logic [4:0] S_DIV   = 5'd10;
    localparam logic [4:0] S_MUL   = 5'd11;
    localparam logic [4:0] S_CMPW  = 5'd12;
    localparam logic [4:0] S_FIX   = 5'd13;
    localparam logic [4:0] S_FIXW  = 5'd14;
    localparam logic [4:0] S_AEND  = 5'd15;
    localparam logic [4:0] S_OFF   = 5'd16;
    localparam logic [4:0] S_OFFW  = 5'd17;
    localparam logic [4:0] S_RD    = 5'd18;
    localparam logic [4:0] S_RDW   = 5'd19;
    localparam logic [4:0] S_REL   = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;
    localparam logic [4:0] S_ENDW  = 5'd22;
    localparam logic [4:0] S_RDW2  = 5'd23;

    logic [4:0] r_st, n_st;
    logic [AW-1:0] r_base;
    logic [4:0] r_shift_raw;
    logic [CW-1:0] r_ppages;
    logic [6:0] r_falign;
    logic [PW-1:0] r_nss, r_avail;
    gppa_pkg::t_req r_req;
    gppa_pkg::t_rsp r_rsp;
    logic r_ovalid;
    logic [PW:0] r_i, r_cnt, r_need, r_first;
    logic r_pass2;
    logic [AW:0] r_acc, r_start;
    logic [AW:0] r_rem;
    logic [AW:0] r_quo;
    logic [5:0] r_bit;
    logic [2:0] r_mbit;
    logic [AW:0] r_prod;

    logic [4:0] w_sh;
    logic [PW-1:0] w_np;
    logic [6:0] w_front;
    logic [SW:0] w_need;
    logic w_we;
    logic [IW-1:0] w_wa, w_ra;
    logic [EW-1:0] w_wd, w_rd;
    logic [1:0] a_fn;
    logic [AW:0] a_a, a_b, a_sum;
    logic a_lt;

    always_comb begin
        if (r_shift_raw < 5'(gppa_pkg::MinShift)) w_sh = 5'(gppa_pkg::MinShift);
        else if (r_shift_raw > 5'(gppa_pkg::MaxShift)) w_sh = 5'(gppa_pkg::MaxShift);
        else w_sh = r_shift_raw;
        w_np = (PW'(r_ppages) > PW'(PAGES)) ? PW'(PAGES) : PW'(r_ppages);
        w_front = (r_falign == 7'd0) ? 7'd1 : r_falign;
        w_need = {1'b0, r_req.request_size >> w_sh} + (SW + 1)'(1)
                 + (((r_req.request_size & ((SW'(1) << w_sh) - 1'b1)) != '0)
                    ? (SW + 1)'(1) : (SW + 1)'(0));
    end

    gppa_ram #(.Width(EW), .Depth(PAGES)) u_tbl (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra), .o_rdata(w_rd)
    );

    gppa_addr_unit u_alu (
        .i_clk(i_clk), .i_fn(a_fn), .i_a(a_a), .i_b(a_b), .o_sum(a_sum), .o_lt(a_lt)
    );

    assign i_req.ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data = r_rsp;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_i[IW-1:0];
        w_wd = {CW'(r_need), r_req.request_size};
        w_ra = r_i[IW-1:0];
        a_fn = gppa_pkg::ALU_PASS;
        a_a = '0;
        a_b = '0;
        unique case (r_st)
            S_CLR: begin
                w_we = 1'b1;
                w_wd = '0;
            end
            S_MARK: w_we = r_i < r_first + r_need;
            S_REL: begin
                w_we = (r_i < r_first) && (r_i < (PW + 1)'(w_np));
                w_wd = '0;
            end
            S_ST: begin
                a_fn = gppa_pkg::ALU_ADD;
                a_a = {1'b0, r_base};
                a_b = (AW + 1)'(r_first) << w_sh;
            end
            S_LAST: begin
                a_fn = gppa_pkg::ALU_SUB;
                a_a = a_sum + (AW + 1)'(r_req.request_size);
                a_b = (AW + 1)'(1);
            end
            S_BND: begin
                a_fn = gppa_pkg::ALU_SUB;
                a_a = (((a_sum >> w_sh) + 1'b1) << w_sh);
                a_b = (AW + 1)'(r_req.request_size);
            end
            S_FIX: begin
                a_a = r_prod;
                a_b = r_start;
            end
            S_AEND: begin
                a_fn = gppa_pkg::ALU_ADD;
                a_a = r_prod;
                a_b = (AW + 1)'(1) << w_sh;
            end
            S_OFF: begin
                a_fn = gppa_pkg::ALU_SUB;
                a_a = {1'b0, r_req.address};
                a_b = {1'b0, r_base};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_CLR:   if (r_i == (PW + 1)'(PAGES - 1)) n_st = S_IDLE;
            S_IDLE:  if (i_req.valid && i_req.ready) n_st = S_NEED;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_i <= '0;
            r_base <= '0;
            r_shift_raw <= 5'(gppa_pkg::MinShift);
            r_ppages <= CW'(1024);
            r_falign <= 7'(gppa_pkg::DefFrontAlign);
            r_nss <= '0;
            r_avail <= PW'(1024);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gppa_pkg::REG_POOL_BASE:   r_base <= i_cfg_data[AW-1:0];
                    gppa_pkg::REG_PAGE_SHIFT:  r_shift_raw <= i_cfg_data[4:0];
                    gppa_pkg::REG_POOL_PAGES:  r_ppages <= i_cfg_data[CW-1:0];
                    gppa_pkg::REG_FRONT_ALIGN: r_falign <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (r_ovalid && o_rsp.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_i <= r_i + 1'b1;
                    r_st <= n_st;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        r_rsp <= '0;
                        r_st <= S_NEED;
                    end
                end
                S_NEED: begin
                    r_need <= (w_need > (SW + 1)'({(PW + 1){1'b1}})) ? '1
                              : (PW + 1)'(w_need);
                    r_first <= (PW + 1)'(r_nss);
                    r_i <= (PW + 1)'(r_nss);
                    r_cnt <= '0;
                    r_pass2 <= 1'b0;
                    if (r_req.op == gppa_pkg::OP_ALLOC) begin
                        r_st <= (r_req.request_size == 0) ? S_OUT : S_SCAN;
                    end else if (r_req.op == gppa_pkg::OP_COUNT) begin
                        r_rsp.ok <= 1'b1;
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_OFF;
                    end
                end
                S_SCAN: begin
                    if (r_need > (PW + 1)'(r_avail)) begin
                        r_st <= S_OUT;
                    end else if (r_cnt == r_need) begin
                        r_first <= r_i - r_need;
                        r_i <= r_i - r_need;
                        r_st <= S_MARK;
                    end else if (r_i >= (PW + 1)'(w_np)) begin
                        if (r_first == 0 || r_pass2) begin
                            r_st <= S_OUT;
                        end else begin
                            r_pass2 <= 1'b1;
                            r_first <= '0;
                            r_i <= '0;
                            r_cnt <= '0;
                        end
                    end else begin
                        r_st <= S_SCANW;
                    end
                end
                S_SCANW: r_st <= S_RDW;
                S_RDW: begin
                    r_cnt <= (w_rd[EW-1:SW] == 0) ? r_cnt + 1'b1 : '0;
                    r_i <= r_i + 1'b1;
                    r_st <= S_SCAN;
                end
                S_MARK: begin
                    if (r_i < r_first + r_need) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_nss <= PW'(r_first + r_need);
                        r_avail <= r_avail - PW'(r_need);
                        r_st <= S_ST;
                    end
                end
                S_ST: r_st <= S_LAST;
                S_LAST: begin
                    r_start <= a_sum;
                    r_st <= S_BND;
                end
                S_BND: begin
                    r_acc <= a_sum;
                    r_st <= S_DIV0;
                end
                S_DIV0: begin
                    r_acc <= a_sum;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= 6'(AW);
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if ({r_rem[AW-1:0], r_acc[r_bit]} >= (AW + 1)'(w_front)) begin
                        r_rem <= {r_rem[AW-1:0], r_acc[r_bit]} - (AW + 1)'(w_front);
                        r_quo[r_bit] <= 1'b1;
                    end else begin
                        r_rem <= {r_rem[AW-1:0], r_acc[r_bit]};
                    end
                    if (r_bit == 0) begin
                        r_prod <= '0;
                        r_mbit <= 3'd6;
                        r_st <= S_MUL;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod <= (r_prod << 1)
                              + (w_front[r_mbit] ? r_quo : '0);
                    if (r_mbit == 0) r_st <= S_FIX;
                    else r_mbit <= r_mbit - 1'b1;
                end
                S_FIX: r_st <= S_FIXW;
                S_FIXW: r_st <= a_lt ? S_AEND : S_CMPW;
                S_AEND: r_st <= S_ENDW;
                S_ENDW: begin
                    r_prod <= a_sum;
                    r_st <= S_CMPW;
                end
                S_CMPW: begin
                    r_rsp.ok <= 1'b1;
                    r_rsp.block_address <= r_prod[AW-1:0];
                    r_st <= S_OUT;
                end
                S_OFF: r_st <= S_OFFW;
                S_OFFW: begin
                    if (r_req.address < r_base ||
                        (a_sum[AW:0] >> w_sh) >= (AW + 1)'(w_np)) begin
                        r_st <= S_OUT;
                    end else begin
                        r_i <= (PW + 1)'(a_sum >> w_sh);
                        r_rsp.ok <= 1'b1;
                        r_st <= S_RD;
                    end
                end
                S_RD: r_st <= S_RDW2;
                S_RDW2: begin
                    if (r_req.op == gppa_pkg::OP_QUERY) begin
                        r_rsp.block_size <= w_rd[SW-1:0];
                        r_st <= S_OUT;
                    end else begin
                        r_need <= (PW + 1)'(w_rd[EW-1:SW]);
                        r_first <= r_i + (PW + 1)'(w_rd[EW-1:SW]);
                        r_avail <= ({1'b0, r_avail} + (PW + 1)'(w_rd[EW-1:SW])
                                    > (PW + 1)'(2047)) ? PW'(2047)
                                   : PW'({1'b0, r_avail} + (PW + 1)'(w_rd[EW-1:SW]));
                        r_st <= S_REL;
                    end
                end
                S_REL: begin
                    if (r_i < r_first && r_i < (PW + 1)'(w_np)) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_rsp.free_pages <= CW'(r_avail);
                    r_rsp.used_pages <= (r_avail > w_np) ? '0 : CW'(w_np - r_avail);
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    property p_one_item;
        @(posedge i_clk) disable iff (!i_rst_n) r_ovalid |-> !i_req.ready;
    endproperty
    a_one_item: assert property (p_one_item) else $error("ready while result held");
    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> r_avail <= PW'(2047)) else $error("avail range");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_rsp.ok) |-> r_rsp.block_address == '0) else $error("fail addr");
endmodule
`default_nettype wire

### sim/guard_page_pool_allocator_tb.sv
`timescale 1ns / 1ps
module guard_page_pool_allocator_tb;
    localparam int unsigned NPAGES = 1024;
    localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
    localparam int unsigned CYCLE_LIMIT = 12_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [gppa_pkg::CfgIdxW-1:0] i_cfg_idx = '0;
    logic [gppa_pkg::CfgDataW-1:0] i_cfg_data = '0;

    gppa_req_if req_if();
    gppa_rsp_if rsp_if();

    guard_page_pool_allocator #(.PAGES(NPAGES)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req(req_if),
        .o_rsp(rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // allocator shadow state
    longint unsigned pool_base;
    int unsigned page_shift, pool_pages, front_align;
    int unsigned run_len [NPAGES];
    int unsigned stored_sz [NPAGES];
    int unsigned next_start, avail_pages;

    gppa_pkg::t_req pend_q[$];
    gppa_pkg::t_rsp rsp_q[$];
    longint unsigned live_blocks[$];
    int unsigned tx_idle, rx_idle;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit req_fire = 1'b0;

    function automatic int unsigned shift_eff();
        if (page_shift < gppa_pkg::MinShift) return gppa_pkg::MinShift;
        if (page_shift > gppa_pkg::MaxShift) return gppa_pkg::MaxShift;
        return page_shift;
    endfunction

    function automatic int unsigned pages_eff();
        return (pool_pages > NPAGES) ? NPAGES : pool_pages;
    endfunction

    function automatic void write_shadow(logic [gppa_pkg::CfgIdxW-1:0] idx,
                                         longint unsigned v);
        case (idx)
            gppa_pkg::REG_POOL_BASE: pool_base = v & MASK48;
            gppa_pkg::REG_PAGE_SHIFT: page_shift = 32'(v & 64'h1F);
            gppa_pkg::REG_POOL_PAGES: pool_pages = 32'(v & 64'h7FF);
            gppa_pkg::REG_FRONT_ALIGN: front_align = 32'(v & 64'h7F);
            default: ;
        endcase
    endfunction

    function automatic int find_run(int unsigned need);
        int unsigned first, lim, i, cnt;
        first = next_start;
        lim = pages_eff();
        forever begin
            i = first;
            cnt = 0;
            while (i < lim && cnt < need) begin
                if (run_len[i] == 0) cnt++;
                else cnt = 0;
                i++;
            end
            if (cnt == need) return int'(i - need);
            if (first == 0) return -1;
            first = 0;
        end
    endfunction

    function automatic gppa_pkg::t_rsp allocator_step(gppa_pkg::t_req r);
        gppa_pkg::t_rsp o;
        int unsigned sh, np, need, st, n, sum, i;
        longint unsigned psize, front, start, last, boundary, aligned, pend;
        int s;
        o = '0;
        sh = shift_eff();
        np = pages_eff();
        if (r.op == gppa_pkg::OP_ALLOC) begin
            if (r.request_size != 0) begin
                psize = 64'd1 << sh;
                need = (r.request_size >> sh) + 1;
                if ((r.request_size & (psize - 1)) != 0) need++;
                if (need <= avail_pages) begin
                    s = find_run(need);
                    if (s >= 0) begin
                        st = s;
                        front = (front_align != 0) ? front_align : 1;
                        next_start = st + need;
                        avail_pages -= need;
                        for (i = st; i < st + need && i < NPAGES; i++) begin
                            run_len[i] = need;
                            stored_sz[i] = r.request_size;
                        end
                        start = pool_base + (longint'(st) << sh);
                        last = start + r.request_size - 1;
                        boundary = ((last >> sh) + 1) << sh;
                        aligned = ((boundary - r.request_size) / front) * front;
                        if (aligned < start) aligned += psize;
                        o.block_address = aligned & MASK48;
                        o.ok = 1'b1;
                    end
                end
            end
        end else if (r.op == gppa_pkg::OP_FREE || r.op == gppa_pkg::OP_QUERY) begin
            pend = pool_base + (longint'(np) << sh);
            if (r.address >= pool_base && r.address < pend) begin
                st = (r.address - pool_base) >> sh;
                o.ok = 1'b1;
                if (r.op == gppa_pkg::OP_QUERY) begin
                    o.block_size = stored_sz[st];
                end else begin
                    n = run_len[st];
                    sum = avail_pages + n;
                    avail_pages = (sum > 2047) ? 2047 : sum;
                    for (i = st; i < st + n && i < np; i++) begin
                        run_len[i] = 0;
                        stored_sz[i] = 0;
                    end
                end
            end
        end else begin
            o.ok = 1'b1;
        end
        o.free_pages = avail_pages;
        o.used_pages = (avail_pages > np) ? 0 : np - avail_pages;
        return o;
    endfunction

    function automatic gppa_pkg::t_req random_req();
        gppa_pkg::t_req r;
        int unsigned sh, pick, k;
        longint unsigned span;
        sh = shift_eff();
        span = longint'(pages_eff()) << sh;
        pick = $urandom_range(99);
        r.op = gppa_pkg::OP_ALLOC;
        r.request_size = $urandom_range(1, 2 << sh);
        r.address = (pool_base + {$urandom, $urandom} % span) & MASK48;
        if (pick < 10) begin
            r.op = $urandom;
            r.request_size = $urandom;
            r.address = {$urandom, $urandom};
        end else if (pick < 55) begin
            k = $urandom_range(9);
            if (k < 3) r.request_size = $urandom_range(1, 16);
            else if (k < 5) r.request_size = $urandom_range(1, 4) << sh;
            else if (k == 5) r.request_size = $urandom;
        end else if (pick < 95) begin
            r.op = (pick < 80) ? gppa_pkg::OP_FREE : gppa_pkg::OP_QUERY;
            if (live_blocks.size() > 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(live_blocks.size() - 1);
                r.address = live_blocks[k];
                if (r.op == gppa_pkg::OP_FREE) live_blocks.delete(k);
            end
        end else begin
            r.op = gppa_pkg::OP_COUNT;
        end
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_if.valid || req_fire) begin
                if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                    req_if.valid <= 1'b1;
                    req_if.data <= pend_q.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        gppa_pkg::t_rsp want, got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        req_fire = i_rst_n && req_if.valid && req_if.ready;
        if (req_fire) rsp_q.push_back(allocator_step(req_if.data));
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (rsp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %p", got);
            end else begin
                want = rsp_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                end
                if (want.ok && want.block_address != 0 && live_blocks.size() < 64)
                    live_blocks.push_back(want.block_address);
            end
        end
    end

    task automatic wait_drained();
        while (pend_q.size() != 0 || rsp_q.size() != 0 || req_if.valid) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [gppa_pkg::CfgIdxW-1:0] idx, longint unsigned v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        write_shadow(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic push(logic [1:0] op, int unsigned sz, longint unsigned addr);
        gppa_pkg::t_req r;
        r.op = op;
        r.request_size = sz;
        r.address = addr;
        pend_q.push_back(r);
    endtask

    task automatic run_phase(longint unsigned base, int unsigned sh, int unsigned np,
                             int unsigned al, int unsigned tx, int unsigned rx,
                             int unsigned count);
        cfg_write(gppa_pkg::REG_POOL_BASE, base);
        cfg_write(gppa_pkg::REG_PAGE_SHIFT, sh);
        cfg_write(gppa_pkg::REG_POOL_PAGES, np);
        cfg_write(gppa_pkg::REG_FRONT_ALIGN, al);
        tx_idle = tx;
        rx_idle = rx;
        live_blocks.delete();
        repeat (count / 2) pend_q.push_back(random_req());
        wait_drained();
        repeat (count - count / 2) pend_q.push_back(random_req());
        wait_drained();
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        pool_base = 0;
        page_shift = 12;
        pool_pages = 1024;
        front_align = gppa_pkg::DefFrontAlign;
        foreach (run_len[i]) begin
            run_len[i] = 0;
            stored_sz[i] = 0;
        end
        next_start = 0;
        avail_pages = 1024;
        tx_idle = 11;
        rx_idle = 80;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        push(gppa_pkg::OP_COUNT, 0, 0);
        push(gppa_pkg::OP_ALLOC, 0, 0);
        push(gppa_pkg::OP_ALLOC, 1, 0);
        push(gppa_pkg::OP_ALLOC, 4096, 0);
        push(gppa_pkg::OP_ALLOC, 26'h3FF_FFFF, 0);
        push(gppa_pkg::OP_ALLOC, 4097, 0);
        push(gppa_pkg::OP_QUERY, 0, 48'h0);
        push(gppa_pkg::OP_QUERY, 0, 48'h2FFF);
        push(gppa_pkg::OP_FREE, 0, 48'h3000);
        push(gppa_pkg::OP_FREE, 0, 48'h3000);
        push(gppa_pkg::OP_FREE, 0, 48'h7FF000);
        push(gppa_pkg::OP_QUERY, 0, 48'h3FF_FFFF);
        push(gppa_pkg::OP_QUERY, 0, 48'h400_0000);
        push(gppa_pkg::OP_FREE, 0, 48'hFFFF_FFFF_FFFF);
        push(gppa_pkg::OP_ALLOC, 4 << 20, 0);
        push(gppa_pkg::OP_ALLOC, 2000 << 12, 0);
        push(gppa_pkg::OP_ALLOC, 1, 0);
        push(gppa_pkg::OP_FREE, 0, 48'h0);
        push(gppa_pkg::OP_ALLOC, 17, 0);
        push(gppa_pkg::OP_COUNT, 26'h3FF_FFFF, 48'hFFFF_FFFF_FFFF);
        wait_drained();

        run_phase(48'h0, 12, 1024, 16, 11, 80, 70);
        run_phase(48'hFFFF_FF00_0000, 16, 40, 7, 80, 11, 70);
        run_phase(48'h1234_5000, 31, 2047, 0, 0, 0, 70);
        run_phase(48'hFFFF_FFFF_F000, 0, 2, 64, 0, 0, 50);
        run_phase(48'h8000_0000_0000, 13, 12, 127, 0, 0, 20);

        repeat (200) @(posedge i_clk);
        if (errors == 0 && rsp_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### guard_page_pool_allocator.f
rtl/core/gppa_pkg.sv
rtl/core/gppa_req_if.sv
rtl/core/gppa_rsp_if.sv
rtl/core/gppa_ram.sv
rtl/core/gppa_addr_unit.sv
rtl/core/guard_page_pool_allocator.sv
sim/guard_page_pool_allocator_tb.sv
